/* rtl/rnv_pkg.sv */
// Package for the reference name validator: character codes, the
// per-name state type and the ".lock" suffix tracker.
// No dependencies.
`timescale 1ns / 1ps

package rnv_pkg;

   // Character codes used by the rules
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;
   localparam logic [7:0] CH_LOW_O  = 8'h6F;
   localparam logic [7:0] CH_LOW_C  = 8'h63;
   localparam logic [7:0] CH_LOW_K  = 8'h6B;
   localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

   // Progress through ".lock": number of suffix bytes matched
   typedef enum logic [2:0] {
      LOCK_NONE = 3'd0,
      LOCK_DOT  = 3'd1,
      LOCK_L    = 3'd2,
      LOCK_O    = 3'd3,
      LOCK_C    = 3'd4,
      LOCK_FULL = 3'd5
   } lock_prog_type;

   // State carried across the bytes of one name
   typedef struct packed {
      logic          failed;
      logic          prev_dot;
      logic          prev_at;
      logic          prev_slash;
      logic          any_slash;
      logic          comp_start;
      lock_prog_type lock_prog;
      logic          all_upper;
   } rnv_state_type;

   localparam rnv_state_type RNV_STATE_RESET = '{
      failed:     1'b0,
      prev_dot:   1'b0,
      prev_at:    1'b0,
      prev_slash: 1'b0,
      any_slash:  1'b0,
      comp_start: 1'b1,
      lock_prog:  LOCK_NONE,
      all_upper:  1'b1
   };

   // Advance the ".lock" suffix match by one byte
   function automatic lock_prog_type next_lock(input lock_prog_type p, input logic [7:0] c);
      lock_prog_type r;
      r = LOCK_NONE;
      if (c == CH_DOT) begin
         r = LOCK_DOT;
      end else if (c == CH_LOW_L && p == LOCK_DOT) begin
         r = LOCK_L;
      end else if (c == CH_LOW_O && p == LOCK_L) begin
         r = LOCK_O;
      end else if (c == CH_LOW_C && p == LOCK_O) begin
         r = LOCK_C;
      end else if (c == CH_LOW_K && p == LOCK_C) begin
         r = LOCK_FULL;
      end
      return r;
   endfunction

endpackage

/* rtl/ref_name_validator.sv */
// A word accepted into the input register has its verdict registered in the result register,
// from which rsp_ can take it.
// Throughput: one name byte per cycle unless a result would overwrite an unread one; the name
// state update is computed combinationally from the input register, so bytes flow back to back.
// Only bytes marked last, or empty-name words, produce a result word.
// Reset (synchronous, active high) empties both stages and returns the
// name state to the start of a new name.
//
// Top level of the reference name validator. Depends on rnv_pkg.
`timescale 1ns / 1ps

module ref_name_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_is_last,
   input  logic       req_name_empty,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_name_valid
);

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       in_empty_ff;

   // Name state and result register
   rnv_pkg::rnv_state_type state_ff, state_in, upd;
   logic       out_valid_ff, out_valid_in;
   logic       out_name_valid_ff, out_name_valid_in;

   logic gives_result, advance, bad_char, is_upper, verdict;

   // Pipeline control: an item moves on unless its result would overwrite
   // an unread one
   assign gives_result = in_last_ff | in_empty_ff;
   assign advance      = in_valid_ff & (~gives_result | ~out_valid_ff | rsp_ready);
   assign req_ready    = ~in_valid_ff | advance;

   // Capture input word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_ch_ff    <= req_ch;
         in_last_ff  <= req_is_last;
         in_empty_ff <= req_name_empty;
      end
   end

   // Classify the byte
   always_comb begin
      bad_char = (in_ch_ff < rnv_pkg::CH_CTRL_LIMIT) || (in_ch_ff == rnv_pkg::CH_DEL)
               || (in_ch_ff == rnv_pkg::CH_STAR)   || (in_ch_ff == rnv_pkg::CH_COLON)
               || (in_ch_ff == rnv_pkg::CH_QUEST)  || (in_ch_ff == rnv_pkg::CH_LBRACK)
               || (in_ch_ff == rnv_pkg::CH_DQUOTE) || (in_ch_ff == rnv_pkg::CH_CARET)
               || (in_ch_ff == rnv_pkg::CH_TILDE)  || (in_ch_ff == rnv_pkg::CH_SPACE)
               || (in_ch_ff == rnv_pkg::CH_TAB);
      is_upper = ((in_ch_ff >= rnv_pkg::CH_UP_A) && (in_ch_ff <= rnv_pkg::CH_UP_Z))
               || (in_ch_ff == rnv_pkg::CH_UNDER);
   end

   // Fold the byte into the name state
   always_comb begin
      upd = state_ff;
      if (bad_char) begin
         upd.failed = 1'b1;
      end
      if (in_ch_ff == rnv_pkg::CH_DOT && (state_ff.prev_dot || state_ff.comp_start)) begin
         upd.failed = 1'b1;
      end
      if (in_ch_ff == rnv_pkg::CH_LBRACE && state_ff.prev_at) begin
         upd.failed = 1'b1;
      end
      if (in_ch_ff == rnv_pkg::CH_SLASH && (state_ff.prev_slash || state_ff.comp_start
                                            || state_ff.lock_prog == rnv_pkg::LOCK_FULL)) begin
         upd.failed = 1'b1;
      end
      if (!is_upper) begin
         upd.all_upper = 1'b0;
      end
      if (in_ch_ff == rnv_pkg::CH_SLASH) begin
         upd.any_slash  = 1'b1;
         upd.comp_start = 1'b1;
         upd.lock_prog  = rnv_pkg::LOCK_NONE;
      end else begin
         upd.comp_start = 1'b0;
         upd.lock_prog  = rnv_pkg::next_lock(state_ff.lock_prog, in_ch_ff);
      end
      upd.prev_dot   = (in_ch_ff == rnv_pkg::CH_DOT);
      upd.prev_at    = (in_ch_ff == rnv_pkg::CH_AT);
      upd.prev_slash = (in_ch_ff == rnv_pkg::CH_SLASH);

      verdict = ~upd.failed & ~upd.prev_slash & (upd.lock_prog != rnv_pkg::LOCK_FULL)
              & (upd.any_slash | upd.all_upper) & ~in_empty_ff;
   end

   // Next state and result word
   always_comb begin
      state_in          = state_ff;
      out_valid_in      = out_valid_ff & ~rsp_ready;
      out_name_valid_in = out_name_valid_ff;
      if (advance) begin
         if (gives_result) begin
            state_in          = rnv_pkg::RNV_STATE_RESET;
            out_valid_in      = 1'b1;
            out_name_valid_in = verdict;
         end else begin
            state_in = upd;
         end
      end
   end

   // Hold state and result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rnv_pkg::RNV_STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_name_valid_ff <= out_name_valid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_name_valid = out_name_valid_ff;

   // Checks
   a_empty_invalid: assert property (@(posedge clock) disable iff (reset)
      (advance && in_empty_ff) |=> (rsp_valid && !rsp_name_valid))
      else $error("empty name did not give an invalid verdict");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && gives_result) |=> (state_ff == rnv_pkg::RNV_STATE_RESET))
      else $error("name state not cleared after a verdict");

   a_lock_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.lock_prog <= rnv_pkg::LOCK_FULL)
      else $error("lock suffix progress out of range");

   a_no_result_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(advance && gives_result))
      else $error("result overwritten while stalled");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input not ready while the input register is empty");

endmodule
